// ----- rtl/swt3d_pkg.sv -----
// Types and constants for the three-device SPI word transmitter.
// Depends on nothing; used by spi_word_transmitter_three_devices_top.
`timescale 1ns / 1ps
`default_nettype none

package swt3d_pkg;

   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_START = 1'b1;

   localparam logic [1:0] DEV_TX  = 2'd0;
   localparam logic [1:0] DEV_RX  = 2'd1;
   localparam logic [1:0] DEV_DAC = 2'd2;

   localparam int unsigned PIN_COUNT  = 9;
   localparam int unsigned BYTE_BITS  = 8;
   localparam logic [3:0]  BITS_START = 4'd8;

   // bit order: tx clock, data, latch, rx clock, data, latch, dac clock, data, sync
   localparam logic [PIN_COUNT-1:0] PINS_RESET = 9'h124;

   localparam logic [3:0] PIN_CLOCK = 4'd0;
   localparam logic [3:0] PIN_DATA  = 4'd1;
   localparam logic [3:0] PIN_FRAME = 4'd2;

   typedef enum logic [2:0] {
      PH_IDLE       = 3'd0,
      PH_BIT_FIRST  = 3'd1,
      PH_BIT_SECOND = 3'd2,
      PH_BYTE_END   = 3'd3,
      PH_FRAME_END  = 3'd4
   } phase_type;

   typedef struct packed {
      logic        kind;
      logic [1:0]  device;
      logic [31:0] word_data;
      logic [1:0]  byte_count_less_one;
   } req_type;

   typedef struct packed {
      logic tx_clock;
      logic tx_serial;
      logic tx_latch;
      logic rx_clock;
      logic rx_serial;
      logic rx_latch;
      logic dac_clock;
      logic dac_serial;
      logic dac_frame;
      logic busy_res;
      logic frame_done;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/spi_word_transmitter_three_devices_top.sv -----
// A response is registered, valid in the cycle after acceptance; one request per cycle
// while rsp_ready is high; the pin sequencer updates on every accepted request.
// A new request is taken while the response register drains in the same cycle.
// Reset: synchronous, active high; sequencer idle, frame lines high, clocks and data low.
// Top level of the SPI word transmitter; uses swt3d_pkg for types and constants.
`timescale 1ns / 1ps
`default_nettype none

module spi_word_transmitter_three_devices_top #(
   parameter int unsigned WORD_BITS = 32
) (
   input  wire                logic clock,
   input  wire                logic reset,
   input  wire                logic req_valid,
   output logic               req_ready,
   input  wire swt3d_pkg::req_type req_data,
   output logic               rsp_valid,
   input  wire                logic rsp_ready,
   output swt3d_pkg::rsp_type rsp_data
);

   localparam int unsigned KEEP_BITS = (WORD_BITS < 32) ? WORD_BITS : 32;

   swt3d_pkg::phase_type              phase_ff, phase_in;
   logic [1:0]                        target_ff, target_in;
   logic [KEEP_BITS-1:0]              shift_word_ff, shift_word_in;
   logic [1:0]                        bytes_left_ff, bytes_left_in;
   logic [3:0]                        bits_left_ff, bits_left_in;
   logic [swt3d_pkg::PIN_COUNT-1:0]   pins_ff, pins_in;
   logic                              done_in;
   logic                              rsp_valid_ff;
   swt3d_pkg::rsp_type                rsp_data_ff, rsp_data_in;
   logic                              req_fire;
   logic [31:0]                       word_pad;
   logic [3:0]                        pin_base;
   logic [3:0]                        start_base;
   logic [3:0]                        bits_dec;
   logic                              cur_bit;
   logic                              is_dac;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign word_pad   = 32'(shift_word_ff);
   assign pin_base   = 4'(target_ff) * 4'd3;
   assign start_base = 4'(req_data.device) * 4'd3;
   assign is_dac     = (target_ff == swt3d_pkg::DEV_DAC);
   assign bits_dec   = bits_left_ff - 4'd1;
   assign cur_bit    = (bits_left_ff == 4'd0 || bits_left_ff > swt3d_pkg::BITS_START) ? 1'b0 :
                       word_pad[{bytes_left_ff, bits_dec[2:0]}];

   always_comb begin
      phase_in      = phase_ff;
      target_in     = target_ff;
      shift_word_in = shift_word_ff;
      bytes_left_in = bytes_left_ff;
      bits_left_in  = bits_left_ff;
      pins_in       = pins_ff;
      done_in       = 1'b0;
      if (req_data.kind == swt3d_pkg::KIND_START) begin
         if (phase_ff == swt3d_pkg::PH_IDLE && req_data.device <= swt3d_pkg::DEV_DAC) begin
            target_in     = req_data.device;
            shift_word_in = req_data.word_data[KEEP_BITS-1:0];
            bytes_left_in = req_data.byte_count_less_one;
            bits_left_in  = swt3d_pkg::BITS_START;
            phase_in      = swt3d_pkg::PH_BIT_FIRST;
            pins_in[start_base + swt3d_pkg::PIN_FRAME] = 1'b0;
         end
      end else begin
         case (phase_ff)
            swt3d_pkg::PH_BIT_FIRST: begin
               pins_in[pin_base + swt3d_pkg::PIN_CLOCK] = is_dac;
               pins_in[pin_base + swt3d_pkg::PIN_DATA]  = cur_bit;
               phase_in = swt3d_pkg::PH_BIT_SECOND;
            end
            swt3d_pkg::PH_BIT_SECOND: begin
               pins_in[pin_base + swt3d_pkg::PIN_CLOCK] = !is_dac;
               bits_left_in = bits_dec;
               phase_in = (bits_dec == 4'd0) ? swt3d_pkg::PH_BYTE_END
                                             : swt3d_pkg::PH_BIT_FIRST;
            end
            swt3d_pkg::PH_BYTE_END: begin
               pins_in[pin_base + swt3d_pkg::PIN_DATA]  = 1'b0;
               pins_in[pin_base + swt3d_pkg::PIN_CLOCK] = 1'b0;
               if (bytes_left_ff == 2'd0) begin
                  phase_in = swt3d_pkg::PH_FRAME_END;
               end else begin
                  bytes_left_in = bytes_left_ff - 2'd1;
                  bits_left_in  = swt3d_pkg::BITS_START;
                  phase_in      = swt3d_pkg::PH_BIT_FIRST;
               end
            end
            swt3d_pkg::PH_FRAME_END: begin
               pins_in[pin_base + swt3d_pkg::PIN_FRAME] = 1'b1;
               done_in  = 1'b1;
               phase_in = swt3d_pkg::PH_IDLE;
            end
            default: begin
               phase_in = swt3d_pkg::PH_IDLE;
            end
         endcase
      end

      rsp_data_in.tx_clock   = pins_in[0];
      rsp_data_in.tx_serial  = pins_in[1];
      rsp_data_in.tx_latch   = pins_in[2];
      rsp_data_in.rx_clock   = pins_in[3];
      rsp_data_in.rx_serial  = pins_in[4];
      rsp_data_in.rx_latch   = pins_in[5];
      rsp_data_in.dac_clock  = pins_in[6];
      rsp_data_in.dac_serial = pins_in[7];
      rsp_data_in.dac_frame  = pins_in[8];
      rsp_data_in.busy_res   = (phase_in != swt3d_pkg::PH_IDLE);
      rsp_data_in.frame_done = done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= swt3d_pkg::PH_IDLE;
         target_ff     <= 2'd0;
         shift_word_ff <= '0;
         bytes_left_ff <= 2'd0;
         bits_left_ff  <= 4'd0;
         pins_ff       <= swt3d_pkg::PINS_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_fire) begin
            phase_ff      <= phase_in;
            target_ff     <= target_in;
            shift_word_ff <= shift_word_in;
            bytes_left_ff <= bytes_left_in;
            bits_left_ff  <= bits_left_in;
            pins_ff       <= pins_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.frame_done) |-> !rsp_data_ff.busy_res)
      else $error("frame_done reported while still busy");

   a_frame_end_done: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.kind == swt3d_pkg::KIND_TICK &&
       phase_ff == swt3d_pkg::PH_FRAME_END) |=> (rsp_valid_ff && rsp_data_ff.frame_done))
      else $error("frame end tick did not report frame_done");

   a_idle_frames_high: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == swt3d_pkg::PH_IDLE) |-> (pins_ff[2] && pins_ff[5] && pins_ff[8]))
      else $error("frame line low while idle");

   a_bits_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != swt3d_pkg::PH_IDLE) |-> (bits_left_ff <= swt3d_pkg::BITS_START))
      else $error("bit counter out of range");

endmodule

`default_nettype wire
